[hw/rtl/mlfq_pkg.sv]
// Package for the three-level feedback scheduler.
// Holds item and result types, function and result codes, controller types and helpers.
// No dependencies.
`timescale 1ns / 1ps

package mlfq_pkg;

    localparam int TASK_COUNT = 16;
    localparam int TID_W      = $clog2(TASK_COUNT);
    localparam int CNT_W      = $clog2(TASK_COUNT + 1);
    localparam int NUM_Q      = 3;
    localparam int ID_W       = 5;
    localparam int CIDX_W     = 2;

    typedef enum logic [1:0] {
        FN_NEW   = 2'd0,
        FN_BURST = 2'd1,
        FN_EXIT  = 2'd2,
        FN_TICK  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        RK_ACK  = 2'd0,
        RK_RAN  = 2'd1,
        RK_IDLE = 2'd2,
        RK_EXIT = 2'd3
    } t_kind;

    typedef enum logic [CIDX_W-1:0] {
        CFG_QUANTUM_ONE   = 2'd0,
        CFG_QUANTUM_TWO   = 2'd1,
        CFG_QUANTUM_THREE = 2'd2,
        CFG_BOOST         = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]  func;
        logic [4:0]  task_id;
        logic [15:0] burst_length;
    } t_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic        boosted;
        logic [4:0]  run_id;
        logic [15:0] requested;
        logic [15:0] used;
        logic [1:0]  level;
        logic [23:0] wait_total;
        logic [23:0] turnaround;
    } t_result;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OP,
        ST_CHECK,
        ST_DRAIN,
        ST_SCHED,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic capture;
        logic op;
        logic check;
        logic drain;
        logic sched;
        logic run;
    } t_cmd;

    typedef struct packed {
        logic boost_due;
        logic drain_empty;
    } t_status;

    function automatic logic [1:0] norm_level(input logic [1:0] l);
        return (l == 2'd0) ? 2'd1 : l;
    endfunction

    function automatic logic [7:0] slice_of(input logic [1:0] l, input logic [7:0] q1,
                                            input logic [7:0] q2, input logic [7:0] q3);
        logic [7:0] q;
        q = (l <= 2'd1) ? q1 : ((l == 2'd2) ? q2 : q3);
        return (q == 8'd0) ? 8'd1 : q;
    endfunction

endpackage

[hw/rtl/mlfq_ctrl.sv]
// Controller state machine of the three-level feedback scheduler.
// Sequences each request through its steps; depends on mlfq_pkg.
`timescale 1ns / 1ps

module mlfq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic [1:0]        i_func,
    input  mlfq_pkg::t_status i_status,
    output mlfq_pkg::t_cmd    o_cmd,
    output logic              busy
);

    mlfq_pkg::t_state r_state;
    mlfq_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mlfq_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        busy    = 1'b1;
        case (r_state)
            mlfq_pkg::ST_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.capture = 1'b1;
                    n_state = (mlfq_pkg::t_func'(i_func) == mlfq_pkg::FN_TICK) ?
                              mlfq_pkg::ST_CHECK : mlfq_pkg::ST_OP;
                end
            end
            mlfq_pkg::ST_OP: begin
                o_cmd.op = 1'b1;
                n_state  = mlfq_pkg::ST_IDLE;
            end
            mlfq_pkg::ST_CHECK: begin
                o_cmd.check = 1'b1;
                n_state = i_status.boost_due ? mlfq_pkg::ST_DRAIN : mlfq_pkg::ST_SCHED;
            end
            mlfq_pkg::ST_DRAIN: begin
                o_cmd.drain = 1'b1;
                if (i_status.drain_empty) begin
                    n_state = mlfq_pkg::ST_SCHED;
                end
            end
            mlfq_pkg::ST_SCHED: begin
                o_cmd.sched = 1'b1;
                n_state = mlfq_pkg::ST_RUN;
            end
            mlfq_pkg::ST_RUN: begin
                o_cmd.run = 1'b1;
                n_state = mlfq_pkg::ST_IDLE;
            end
            default: begin
                n_state = mlfq_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/mlfq_datapath.sv]
// Datapath of the three-level feedback scheduler: task table, three queues,
// configuration registers and the result register. Depends on mlfq_pkg.
`timescale 1ns / 1ps

module mlfq_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mlfq_pkg::t_cmd              i_cmd,
    input  mlfq_pkg::t_item             i_item,
    input  logic                        i_cfg_valid,
    input  logic [mlfq_pkg::CIDX_W-1:0] i_cfg_index,
    input  logic [15:0]                 i_cfg_data,
    output logic                        o_cfg_ready,
    output mlfq_pkg::t_status           o_status,
    output mlfq_pkg::t_result           o_result,
    output logic                        o_result_valid
);

    localparam int MT = mlfq_pkg::TASK_COUNT;
    localparam int TW = mlfq_pkg::TID_W;
    localparam int CW = mlfq_pkg::CNT_W;
    localparam int NQ = mlfq_pkg::NUM_Q;

    logic [7:0]  r_q1, r_q2, r_q3;
    logic [15:0] r_interval, r_phase;
    logic        r_boosted;
    mlfq_pkg::t_item r_item;

    logic [1:0]  r_level [MT];
    logic [15:0] r_req   [MT];
    logic [15:0] r_rem   [MT];
    logic [23:0] r_wait  [MT];
    logic [23:0] r_exec  [MT];

    logic [TW-1:0] r_slot  [NQ][MT];
    logic [TW-1:0] r_hv    [NQ];
    logic [TW-1:0] r_head  [NQ];
    logic [CW-1:0] r_count [NQ];
    logic [MT-1:0] r_queued, n_queued;

    logic          r_run_v, n_run_v;
    logic [TW-1:0] r_run_t, n_run_t;
    logic [7:0]    r_quant, n_quant;

    mlfq_pkg::t_result r_res, n_res;
    logic              r_res_v;

    logic          id_ok, busy_t, boost_due;
    logic [TW-1:0] tix;
    logic [16:0]   rem_sum;
    logic [15:0]   rem_new, run_rem;
    logic [24:0]   tat_sum;
    logic [1:0]    top, cur0, cur_up;
    logic [7:0]    cap;
    logic          push_en, pop_en;
    logic [1:0]    push_q, pop_q;
    logic [TW-1:0] push_t, pop_t;
    logic          la_en, lb_en;
    logic [TW-1:0] la_t, lb_t;
    logic [1:0]    la_v, lb_v;

    assign o_cfg_ready    = 1'b1;
    assign o_result       = r_res;
    assign o_result_valid = r_res_v;

    assign id_ok  = (r_item.task_id != '0) && (r_item.task_id <= mlfq_pkg::ID_W'(MT));
    assign tix    = TW'(r_item.task_id - 5'd1);
    assign busy_t = id_ok && ((r_run_v && (r_run_t == tix)) || r_queued[tix]);
    assign boost_due = r_phase >= r_interval;
    assign o_status.boost_due   = boost_due;
    assign o_status.drain_empty = (r_count[2] == '0) && (r_count[1] == '0);

    assign rem_sum = {1'b0, r_rem[tix]} + {1'b0, r_item.burst_length};
    assign rem_new = rem_sum[16] ? 16'hFFFF : rem_sum[15:0];
    assign tat_sum = {1'b0, r_wait[tix]} + {1'b0, r_exec[tix]};
    assign run_rem = (r_rem[r_run_t] != 16'd0) ? (r_rem[r_run_t] - 16'd1) : 16'd0;
    assign cap     = (r_q1 == 8'd0) ? 8'd1 : r_q1;
    assign top     = (r_count[0] != '0) ? 2'd1 :
                     (r_count[1] != '0) ? 2'd2 :
                     (r_count[2] != '0) ? 2'd3 : 2'd0;
    assign cur0    = mlfq_pkg::norm_level(r_level[r_run_t]);
    assign cur_up  = (cur0 == 2'd3) ? 2'd3 : (cur0 + 2'd1);

    always_comb begin
        push_en = 1'b0; push_q = 2'd0; push_t = '0;
        pop_en  = 1'b0; pop_q  = 2'd0; pop_t  = '0;
        la_en = 1'b0; la_t = '0; la_v = 2'd1;
        lb_en = 1'b0; lb_t = '0; lb_v = 2'd1;
        n_run_v = r_run_v;
        n_run_t = r_run_t;
        n_quant = r_quant;
        n_res   = '0;

        if (i_cmd.op) begin
            case (mlfq_pkg::t_func'(r_item.func))
                mlfq_pkg::FN_NEW: begin
                    n_res.kind = mlfq_pkg::RK_ACK;
                    if (id_ok && !busy_t) begin
                        la_en = 1'b1; la_t = tix; la_v = 2'd1;
                    end
                end
                mlfq_pkg::FN_BURST: begin
                    n_res.kind = mlfq_pkg::RK_ACK;
                    if (id_ok && !busy_t && (rem_new != 16'd0)) begin
                        la_en = 1'b1; la_t = tix;
                        la_v  = mlfq_pkg::norm_level(r_level[tix]);
                        push_en = 1'b1; push_q = la_v - 2'd1; push_t = tix;
                    end
                end
                mlfq_pkg::FN_EXIT: begin
                    n_res.kind = mlfq_pkg::RK_EXIT;
                    if (id_ok) begin
                        n_res.run_id     = r_item.task_id;
                        n_res.wait_total = r_wait[tix];
                        n_res.turnaround = tat_sum[24] ? 24'hFFFFFF : tat_sum[23:0];
                    end
                end
                default: begin
                    n_res.kind = mlfq_pkg::RK_ACK;
                end
            endcase
        end

        if (i_cmd.check && boost_due && r_run_v) begin
            la_en = 1'b1; la_t = r_run_t; la_v = 2'd1;
            if (r_quant > cap) begin
                n_quant = cap;
            end
        end

        if (i_cmd.drain) begin
            if (r_count[2] != '0) begin
                pop_en = 1'b1; pop_q = 2'd2;
            end else if (r_count[1] != '0) begin
                pop_en = 1'b1; pop_q = 2'd1;
            end
            pop_t = r_hv[pop_q];
            if (pop_en) begin
                push_en = 1'b1; push_q = 2'd0; push_t = pop_t;
                la_en = 1'b1; la_t = pop_t; la_v = 2'd1;
            end
        end

        if (i_cmd.sched) begin
            pop_q = (top == 2'd0) ? 2'd0 : (top - 2'd1);
            pop_t = r_hv[pop_q];
            if (!r_run_v) begin
                pop_en = (top != 2'd0);
            end else if (r_quant == 8'd0) begin
                la_en = 1'b1; la_t = r_run_t; la_v = cur_up;
                if ((top != 2'd0) && (top <= cur_up)) begin
                    push_en = 1'b1; push_q = cur_up - 2'd1; push_t = r_run_t;
                    pop_en = 1'b1;
                end else begin
                    n_quant = mlfq_pkg::slice_of(cur_up, r_q1, r_q2, r_q3);
                end
            end else if ((top != 2'd0) && (top < cur0)) begin
                la_en = 1'b1; la_t = r_run_t; la_v = cur0;
                push_en = 1'b1; push_q = cur0 - 2'd1; push_t = r_run_t;
                pop_en = 1'b1;
            end
            if (pop_en) begin
                n_run_v = 1'b1;
                n_run_t = pop_t;
                lb_en = 1'b1; lb_t = pop_t; lb_v = top;
                n_quant = mlfq_pkg::slice_of(top, r_q1, r_q2, r_q3);
            end
        end

        if (i_cmd.run) begin
            n_res.boosted = r_boosted;
            if (r_run_v) begin
                n_res.kind      = mlfq_pkg::RK_RAN;
                n_res.run_id    = mlfq_pkg::ID_W'(r_run_t) + 5'd1;
                n_res.requested = r_req[r_run_t];
                n_res.used      = r_req[r_run_t] - run_rem;
                n_res.level     = cur0;
                if (r_quant != 8'd0) begin
                    n_quant = r_quant - 8'd1;
                end
                if (run_rem == 16'd0) begin
                    n_run_v = 1'b0;
                end
            end else begin
                n_res.kind = mlfq_pkg::RK_IDLE;
            end
        end

        n_queued = r_queued;
        if (pop_en) begin
            n_queued[pop_t] = 1'b0;
        end
        if (push_en) begin
            n_queued[push_t] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q1       <= 8'd2;
            r_q2       <= 8'd4;
            r_q3       <= 8'd8;
            r_interval <= 16'd25;
            r_phase    <= 16'd1;
            r_boosted  <= 1'b0;
            r_run_v    <= 1'b0;
            r_run_t    <= '0;
            r_quant    <= 8'd0;
            r_queued   <= '0;
            r_res_v    <= 1'b0;
            for (int q = 0; q < NQ; q++) begin
                r_head[q]  <= '0;
                r_count[q] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                case (mlfq_pkg::t_cfg_idx'(i_cfg_index))
                    mlfq_pkg::CFG_QUANTUM_ONE:   r_q1 <= i_cfg_data[7:0];
                    mlfq_pkg::CFG_QUANTUM_TWO:   r_q2 <= i_cfg_data[7:0];
                    mlfq_pkg::CFG_QUANTUM_THREE: r_q3 <= i_cfg_data[7:0];
                    mlfq_pkg::CFG_BOOST:         r_interval <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.check) begin
                r_boosted <= boost_due;
                r_phase   <= boost_due ? 16'd1 : (r_phase + 16'd1);
            end
            r_run_v  <= n_run_v;
            r_run_t  <= n_run_t;
            r_quant  <= n_quant;
            r_queued <= n_queued;
            r_res_v  <= i_cmd.op | i_cmd.run;
            for (int q = 0; q < NQ; q++) begin
                r_count[q] <= r_count[q]
                              + CW'(push_en && (push_q == 2'(q)))
                              - CW'(pop_en && (pop_q == 2'(q)));
                if (pop_en && (pop_q == 2'(q))) begin
                    r_head[q] <= r_head[q] + TW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (i_cmd.capture) begin
            r_item <= i_item;
        end
        for (int q = 0; q < NQ; q++) begin
            if (push_en && (push_q == 2'(q))) begin
                r_slot[q][r_head[q] + r_count[q][TW-1:0]] <= push_t;
            end
            if (pop_en && (pop_q == 2'(q))) begin
                if (push_en && (push_q == 2'(q)) && (r_count[q] == CW'(1))) begin
                    r_hv[q] <= push_t;
                end else begin
                    r_hv[q] <= r_slot[pop_q][r_head[pop_q] + TW'(1)];
                end
            end else if (push_en && (push_q == 2'(q)) && (r_count[q] == '0)) begin
                r_hv[q] <= push_t;
            end
        end
        for (int i = 0; i < MT; i++) begin
            if (la_en && (la_t == TW'(i))) begin
                r_level[i] <= la_v;
            end
            if (lb_en && (lb_t == TW'(i))) begin
                r_level[i] <= lb_v;
            end
            if (i_cmd.op && id_ok && (tix == TW'(i))) begin
                if ((mlfq_pkg::t_func'(r_item.func) == mlfq_pkg::FN_NEW) && !busy_t) begin
                    r_req[i]  <= 16'd0;
                    r_rem[i]  <= 16'd0;
                    r_wait[i] <= 24'd0;
                    r_exec[i] <= 24'd0;
                end
                if (mlfq_pkg::t_func'(r_item.func) == mlfq_pkg::FN_BURST) begin
                    r_req[i] <= r_item.burst_length;
                    r_rem[i] <= rem_new;
                end
            end
            if (i_cmd.run) begin
                if (r_queued[i] && (r_wait[i] != 24'hFFFFFF)) begin
                    r_wait[i] <= r_wait[i] + 24'd1;
                end
                if (r_run_v && (r_run_t == TW'(i))) begin
                    r_rem[i] <= run_rem;
                    if (r_exec[i] != 24'hFFFFFF) begin
                        r_exec[i] <= r_exec[i] + 24'd1;
                    end
                end
            end
        end
    end

endmodule

[hw/rtl/mlfq_three_level_scheduler_top.sv]
// Top level of the three-level feedback scheduler.
// Joins mlfq_ctrl and mlfq_datapath; depends on mlfq_pkg.
//
// A request is issued by raising start with i_item while busy is low.
// Each request gives exactly one result on o_result, marked by a one-cycle
// o_result_valid strobe; the receiver cannot stall it.
// New, burst and exit requests pass through the op state before the strobe.
// A tick passes through the check, schedule and run states, with the drain state
// between check and schedule when a boost is due.
// The boost moves one queue entry per cycle through the queue write port.
// busy is high while a request is in progress; a new request may be issued
// in the cycle its predecessor's result is shown.
// Configuration writes on the i_cfg_* channel are always ready; the user must make them
// while the block is idle, as the block itself does not enforce this.
// Reset restores the default quanta and boost interval and empties all queues.
`timescale 1ns / 1ps

module mlfq_three_level_scheduler_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  mlfq_pkg::t_item             i_item,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [mlfq_pkg::CIDX_W-1:0] i_cfg_index,
    input  logic [15:0]                 i_cfg_data,
    output mlfq_pkg::t_result           o_result,
    output logic                        o_result_valid
);

    mlfq_pkg::t_cmd    cmd;
    mlfq_pkg::t_status status;

    mlfq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_func   (i_item.func),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    mlfq_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_item         (i_item),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_cfg_ready    (o_cfg_ready),
        .o_status       (status),
        .o_result       (o_result),
        .o_result_valid (o_result_valid)
    );

endmodule

[hw/rtl/mlfq_checker.sv]
// Port checker for the three-level feedback scheduler, bound to the top level.
// Depends on mlfq_pkg.
`timescale 1ns / 1ps

module mlfq_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input mlfq_pkg::t_result o_result,
    input logic              o_result_valid
);

    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after an accepted request");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe lasted more than one cycle");

    a_ran_has_task: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_result.kind == mlfq_pkg::RK_RAN)) |->
        ((o_result.run_id != 5'd0) && (o_result.level != 2'd0)))
        else $error("run result without task or level");

    a_idle_no_task: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_result.kind == mlfq_pkg::RK_IDLE)) |->
        ((o_result.run_id == 5'd0) && (o_result.used == 16'd0)))
        else $error("idle tick reports a task");

endmodule

bind mlfq_three_level_scheduler_top mlfq_checker u_mlfq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_result       (o_result),
    .o_result_valid (o_result_valid)
);

[tb/mlfq_three_level_scheduler_top_tb.sv]
// Self-checking testbench for the three-level feedback scheduler top level.
// Drives requests and register writes, predicts every result with its own scheduler model
// and compares field by field; depends on mlfq_pkg and mlfq_three_level_scheduler_top.
`timescale 1ns / 1ps

module mlfq_three_level_scheduler_top_tb;

    localparam int CYCLE_LIMIT = 600000;
    localparam int NT = mlfq_pkg::TASK_COUNT;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        start;
    logic                        busy;
    mlfq_pkg::t_item             i_item;
    logic                        i_cfg_valid;
    logic                        o_cfg_ready;
    logic [mlfq_pkg::CIDX_W-1:0] i_cfg_index;
    logic [15:0]                 i_cfg_data;
    mlfq_pkg::t_result           o_result;
    logic                        o_result_valid;

    mlfq_three_level_scheduler_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_result       (o_result),
        .o_result_valid (o_result_valid)
    );

    // Scheduler state as the testbench sees it.
    int        quant_one, quant_two, quant_three, boost_every;
    int        boost_tick;
    bit [1:0]  task_lvl [NT];
    bit [15:0] task_req [NT];
    bit [15:0] task_left [NT];
    bit [23:0] task_wait [NT];
    bit [23:0] task_exec [NT];
    int        fifo_slot [3][NT];
    int        fifo_head [3];
    int        fifo_cnt [3];
    bit        cpu_busy;
    int        cpu_task;
    int        slice_left;
    bit        created [NT];

    mlfq_pkg::t_result pending_results [$];
    int        errors;
    int        items_sent;
    int        results_seen;
    int        boosts_seen;
    int        cycles;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic int slice_for(int l);
        int q;
        q = (l <= 1) ? quant_one : ((l == 2) ? quant_two : quant_three);
        return (q == 0) ? 1 : q;
    endfunction

    function automatic int level_of(int t);
        return (task_lvl[t] == 0) ? 1 : task_lvl[t];
    endfunction

    function automatic void fifo_push(int l, int t);
        int q;
        q = l - 1;
        if (fifo_cnt[q] >= NT) return;
        fifo_slot[q][(fifo_head[q] + fifo_cnt[q]) % NT] = t;
        fifo_cnt[q]++;
    endfunction

    function automatic int fifo_pop(int l);
        int q, t;
        q = l - 1;
        t = fifo_slot[q][fifo_head[q]];
        fifo_head[q] = (fifo_head[q] + 1) % NT;
        fifo_cnt[q]--;
        return t;
    endfunction

    function automatic bit waiting_in_fifo(int t);
        for (int q = 0; q < 3; q++)
            for (int i = 0; i < fifo_cnt[q]; i++)
                if (fifo_slot[q][(fifo_head[q] + i) % NT] == t) return 1'b1;
        return 1'b0;
    endfunction

    function automatic int highest_ready();
        for (int q = 0; q < 3; q++)
            if (fifo_cnt[q] != 0) return q + 1;
        return 0;
    endfunction

    function automatic void dispatch_from(int l);
        cpu_task = fifo_pop(l);
        cpu_busy = 1'b1;
        task_lvl[cpu_task] = 2'(l);
        slice_left = slice_for(l);
    endfunction

    function automatic void boost_all();
        int t, cap;
        for (int l = 3; l >= 2; l--)
            while (fifo_cnt[l-1] != 0) begin
                t = fifo_pop(l);
                task_lvl[t] = 2'd1;
                fifo_push(1, t);
            end
        if (cpu_busy) begin
            task_lvl[cpu_task] = 2'd1;
            cap = (quant_one == 0) ? 1 : quant_one;
            if (slice_left > cap) slice_left = cap;
        end
    endfunction

    function automatic void pick_next();
        int top, cur;
        top = highest_ready();
        if (!cpu_busy) begin
            if (top != 0) dispatch_from(top);
            return;
        end
        cur = level_of(cpu_task);
        if (slice_left == 0) begin
            if (cur < 3) cur++;
            task_lvl[cpu_task] = 2'(cur);
            if (top != 0 && top <= cur) begin
                fifo_push(cur, cpu_task);
                dispatch_from(top);
            end else begin
                slice_left = slice_for(cur);
            end
            return;
        end
        if (top != 0 && top < cur) begin
            task_lvl[cpu_task] = 2'(cur);
            fifo_push(cur, cpu_task);
            dispatch_from(top);
        end
    endfunction

    function automatic mlfq_pkg::t_result schedule_result(mlfq_pkg::t_item it);
        mlfq_pkg::t_result r;
        bit      ok, in_use, boost_now;
        int      t, sum, w;
        r = '0;
        ok = it.task_id >= 1 && it.task_id <= NT;
        t = ok ? it.task_id - 1 : 0;
        in_use = ok && ((cpu_busy && cpu_task == t) || waiting_in_fifo(t));
        case (mlfq_pkg::t_func'(it.func))
            mlfq_pkg::FN_NEW: begin
                if (ok && !in_use) begin
                    task_lvl[t] = 2'd1;
                    task_req[t] = 16'd0;
                    task_left[t] = 16'd0;
                    task_wait[t] = 24'd0;
                    task_exec[t] = 24'd0;
                end
            end
            mlfq_pkg::FN_BURST: begin
                if (ok) begin
                    sum = task_left[t] + it.burst_length;
                    task_req[t] = it.burst_length;
                    task_left[t] = (sum > 65535) ? 16'hFFFF : sum[15:0];
                    if (!in_use && task_left[t] != 0) begin
                        task_lvl[t] = 2'(level_of(t));
                        fifo_push(level_of(t), t);
                    end
                end
            end
            mlfq_pkg::FN_EXIT: begin
                r.kind = mlfq_pkg::RK_EXIT;
                if (ok) begin
                    sum = task_wait[t] + task_exec[t];
                    r.run_id = it.task_id;
                    r.wait_total = task_wait[t];
                    r.turnaround = (sum > 24'hFFFFFF) ? 24'hFFFFFF : sum[23:0];
                end
            end
            default: begin
                boost_now = boost_tick >= boost_every;
                if (boost_now) boost_all();
                boost_tick = boost_now ? 1 : ((boost_tick + 1) & 16'hFFFF);
                pick_next();
                for (int q = 0; q < 3; q++)
                    for (int i = 0; i < fifo_cnt[q]; i++) begin
                        w = fifo_slot[q][(fifo_head[q] + i) % NT];
                        if (task_wait[w] != 24'hFFFFFF) task_wait[w]++;
                    end
                r.boosted = boost_now;
                if (cpu_busy) begin
                    if (slice_left != 0) slice_left--;
                    if (task_left[cpu_task] != 0) task_left[cpu_task]--;
                    if (task_exec[cpu_task] != 24'hFFFFFF) task_exec[cpu_task]++;
                    r.kind = mlfq_pkg::RK_RAN;
                    r.run_id = 5'(cpu_task + 1);
                    r.requested = task_req[cpu_task];
                    r.used = task_req[cpu_task] - task_left[cpu_task];
                    r.level = 2'(level_of(cpu_task));
                    if (task_left[cpu_task] == 0) cpu_busy = 1'b0;
                end else begin
                    r.kind = mlfq_pkg::RK_IDLE;
                end
            end
        endcase
        return r;
    endfunction

    task automatic check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        mlfq_pkg::t_result exp_r;
        if (i_rst_n && o_result_valid) begin
            results_seen++;
            if (o_result.boosted) boosts_seen++;
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding");
                errors++;
            end else begin
                exp_r = pending_results.pop_front();
                check_field("kind", exp_r.kind, o_result.kind);
                check_field("boosted", exp_r.boosted, o_result.boosted);
                check_field("run_id", exp_r.run_id, o_result.run_id);
                check_field("requested", exp_r.requested, o_result.requested);
                check_field("used", exp_r.used, o_result.used);
                check_field("level", exp_r.level, o_result.level);
                check_field("wait_total", exp_r.wait_total, o_result.wait_total);
                check_field("turnaround", exp_r.turnaround, o_result.turnaround);
            end
        end
    end

    // Called at a falling edge; returns at a falling edge with start still high.
    task automatic send_request(mlfq_pkg::t_func f, int id, int len);
        mlfq_pkg::t_item it;
        int    gap;
        it.func = f;
        it.task_id = 5'(id);
        it.burst_length = 16'(len);
        gap = $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_results.push_back(schedule_result(it));
        if (f == mlfq_pkg::FN_NEW && id >= 1 && id <= NT) created[id-1] = 1'b1;
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_reg(mlfq_pkg::t_cfg_idx idx, int value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= 16'(value);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            mlfq_pkg::CFG_QUANTUM_ONE:   quant_one = value & 8'hFF;
            mlfq_pkg::CFG_QUANTUM_TWO:   quant_two = value & 8'hFF;
            mlfq_pkg::CFG_QUANTUM_THREE: quant_three = value & 8'hFF;
            default:                     boost_every = value & 16'hFFFF;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic configure(int q1, int q2, int q3, int interval);
        wait_idle();
        write_reg(mlfq_pkg::CFG_QUANTUM_ONE, q1);
        write_reg(mlfq_pkg::CFG_QUANTUM_TWO, q2);
        write_reg(mlfq_pkg::CFG_QUANTUM_THREE, q3);
        write_reg(mlfq_pkg::CFG_BOOST, interval);
    endtask

    function automatic int bad_id();
        return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(NT + 1, 31);
    endfunction

    task automatic test_basic_requests();
        send_request(mlfq_pkg::FN_TICK, 0, 0);
        send_request(mlfq_pkg::FN_EXIT, 0, 0);
        send_request(mlfq_pkg::FN_EXIT, 31, 16'hFFFF);
        send_request(mlfq_pkg::FN_NEW, 20, 0);
        send_request(mlfq_pkg::FN_BURST, 0, 16'hFFFF);
        send_request(mlfq_pkg::FN_NEW, 1, 0);
        send_request(mlfq_pkg::FN_BURST, 1, 0);
        send_request(mlfq_pkg::FN_BURST, 1, 3);
        send_request(mlfq_pkg::FN_NEW, 1, 0);
        send_request(mlfq_pkg::FN_BURST, 1, 2);
        send_request(mlfq_pkg::FN_NEW, 16, 0);
        send_request(mlfq_pkg::FN_BURST, 16, 16'hFFFF);
        send_request(mlfq_pkg::FN_BURST, 16, 16'hFFFF);
        send_request(mlfq_pkg::FN_NEW, 2, 0);
        send_request(mlfq_pkg::FN_BURST, 2, 1);
        repeat (6) send_request(mlfq_pkg::FN_TICK, 31, 16'hFFFF);
        send_request(mlfq_pkg::FN_EXIT, 1, 0);
        send_request(mlfq_pkg::FN_EXIT, 2, 0);
        send_request(mlfq_pkg::FN_EXIT, 16, 0);
    endtask

    task automatic test_random_mix(int count, int max_len);
        int sel, id, tries;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 45) begin
                send_request(mlfq_pkg::FN_TICK, $urandom_range(0, 31),
                             $urandom_range(0, 16'hFFFF));
            end else if (sel < 75) begin
                tries = 0;
                do begin
                    id = $urandom_range(1, NT);
                    tries++;
                end while ((!created[id-1] || (cpu_busy && cpu_task == id - 1)) && tries < 20);
                if (!created[id-1] || (cpu_busy && cpu_task == id - 1))
                    send_request(mlfq_pkg::FN_TICK, 0, 0);
                else if ($urandom_range(0, 15) == 0)
                    send_request(mlfq_pkg::FN_BURST, id, $urandom_range(0, 16'hFFFF));
                else
                    send_request(mlfq_pkg::FN_BURST, id, $urandom_range(0, max_len));
            end else if (sel < 83) begin
                send_request(mlfq_pkg::FN_NEW, $urandom_range(1, NT),
                             $urandom_range(0, 16'hFFFF));
            end else if (sel < 93) begin
                id = $urandom_range(1, NT);
                if (created[id-1])
                    send_request(mlfq_pkg::FN_EXIT, id, $urandom_range(0, 16'hFFFF));
                else send_request(mlfq_pkg::FN_EXIT, bad_id(), 0);
            end else begin
                send_request(mlfq_pkg::t_func'($urandom_range(0, 2)), bad_id(),
                             $urandom_range(0, 16'hFFFF));
            end
            if ($urandom_range(0, 7) == 0) begin
                start <= 1'b0;
                @(negedge i_clk);
            end
        end
    endtask

    task automatic test_default_settings();
        test_random_mix(350, 12);
    endtask

    task automatic test_shortest_slices();
        configure(1, 1, 1, 1);
        test_random_mix(300, 6);
    endtask

    task automatic test_longest_slices();
        configure(255, 255, 255, 16'hFFFF);
        test_random_mix(300, 30);
    endtask

    task automatic test_mixed_slices();
        configure(1, 3, 6, 7);
        test_random_mix(350, 10);
        configure($urandom_range(1, 255), $urandom_range(1, 255), $urandom_range(1, 255),
                  $urandom_range(1, 40));
        test_random_mix(350, 20);
    endtask

    initial begin
        errors = 0;
        items_sent = 0;
        results_seen = 0;
        boosts_seen = 0;
        start = 1'b0;
        i_item = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_rst_n = 1'b0;
        quant_one = 2;
        quant_two = 4;
        quant_three = 8;
        boost_every = 25;
        boost_tick = 1;
        for (int q = 0; q < 3; q++) begin
            fifo_head[q] = 0;
            fifo_cnt[q] = 0;
        end
        cpu_busy = 1'b0;
        cpu_task = 0;
        slice_left = 0;
        foreach (created[i]) created[i] = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_basic_requests();
        test_default_settings();
        test_shortest_slices();
        test_longest_slices();
        test_mixed_slices();

        wait_idle();
        $display("Sent %0d requests over five register settings; %0d results checked, %0d boosts.",
                 items_sent, results_seen, boosts_seen);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
